// ===== sv/blu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the banded LU solver.
// Used by every module of the block except blu_ram; depends on nothing.
package blu_pkg;

    localparam int MAX_SIZE_DEF = 32;
    localparam int RES_LIMIT    = 32;
    localparam int CW           = 6;     // loop counters, hold 0 .. 63
    localparam int QUEUE_DEPTH  = 4;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 40;

    localparam logic [0:0] CFG_SIZE_IN_USE = 1'b0;
    localparam logic [0:0] CFG_HALF_BW     = 1'b1;

    localparam logic [5:0] SIZE_RESET = 6'd32;
    localparam logic [4:0] HBW_RESET  = 5'd1;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_SOLVE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_ZERO_PIVOT = 2'd1,
        STAT_SATURATED  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic clearing;
        logic q_full;
    } fe_status_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } q16_t;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] acc;
    } acc_sat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_INIT2,
        ST_CHK,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_RND,
        ST_DIVW,
        ST_OUT_RD,
        ST_OUT_EMIT
    } bk_state_t;

    typedef enum logic [1:0] {
        PH_FU,
        PH_FL,
        PH_FWD,
        PH_BWD
    } phase_t;

    // Q16.16 to Q32.32
    function automatic logic signed [63:0] wide_q(input logic signed [31:0] v);
        return {{16{v[31]}}, v, 16'h0000};
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    // Apply sign to a magnitude and saturate to 32 bits
    function automatic q16_t pack_q(input logic [63:0] m, input logic neg);
        q16_t r;
        logic [63:0] nm;
        nm = 64'd0 - m;
        if (neg) begin
            r.sat = (m > 64'h0000_0000_8000_0000);
            r.val = r.sat ? 32'sh8000_0000 : nm[31:0];
        end
        else begin
            r.sat = (m > 64'h0000_0000_7FFF_FFFF);
            r.val = r.sat ? 32'sh7FFF_FFFF : m[31:0];
        end
        return r;
    endfunction

    // acc - p, clamped to the 64-bit range
    function automatic acc_sat_t sat_sub(input logic signed [63:0] acc,
                                         input logic signed [63:0] p);
        acc_sat_t r;
        logic [64:0] d;
        d = {acc[63], acc} - {p[63], p};
        r.sat = d[64] ^ d[63];
        if (r.sat)
            r.acc = d[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            r.acc = d[63:0];
        return r;
    endfunction

endpackage

// ===== sv/banded_lu_linear_solver_core.sv =====
// Banded LU solver top level. Loads are taken one per cycle while s_tready is high and land
// in the stores after passing through the item queue, once the back end is idle. A solve walks
// every band product through one multiply-accumulate unit, and each division goes through
// the bit-serial divider in place of the rounding state; results then leave one at a time,
// each read from the solution store and then emitted, held while m_tready is low.
// After reset the matrix store is cleared, with s_tready held low meanwhile.
module banded_lu_linear_solver_core #(
    parameter int MAX_SIZE = blu_pkg::MAX_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [blu_pkg::S_DATA_W-1:0]  s_tdata,   // row[4:0], col[9:5], value[41:10], zero pad
    input  logic [1:0]                    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [blu_pkg::M_DATA_W-1:0]  m_tdata,   // index[4:0], solution[36:5], zero pad
    output logic [1:0]                    m_tuser,   // status
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [5:0]                    cfg_data
);
    import blu_pkg::*;

    logic [5:0]  size_reg;
    logic [4:0]  hbw_reg;
    fe_status_t  fe_st;
    logic        push, pop, q_empty, q_full, clearing;
    item_t       push_item, pop_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            hbw_reg  <= HBW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_IN_USE: size_reg <= cfg_data;
                CFG_HALF_BW:     hbw_reg  <= cfg_data[4:0];
            endcase
        end
    end

    blu_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .status    (fe_st),
        .push      (push),
        .push_item (push_item)
    );

    blu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    assign fe_st = '{clearing: clearing, q_full: q_full};

    blu_back #(.MAX_SIZE(MAX_SIZE)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (pop_item),
        .q_pop          (pop),
        .size_in_use    (size_reg),
        .half_bandwidth (hbw_reg),
        .clearing       (clearing),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

// ===== sv/blu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/blu_queue.sv =====
// Short item queue between the front end and the execution back end.
// Depends on blu_pkg for the item type.
module blu_queue #(
    parameter int DEPTH = blu_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  blu_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output blu_pkg::item_t pop_item,
    output logic          empty
);
    import blu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [NW-1:0]  cnt_reg;

    assign full     = (cnt_reg == NW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = slot_reg[rd_reg];

    // store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/blu_front.sv =====
// Front end: takes stream transfers, drops unknown kinds and out-of-range loads,
// and pushes the rest into the queue. Depends on blu_pkg.
module blu_front #(
    parameter int MAX_SIZE = blu_pkg::MAX_SIZE_DEF
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [blu_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                    s_tuser,
    input  blu_pkg::fe_status_t           status,
    output logic                          push,
    output blu_pkg::item_t                push_item
);
    import blu_pkg::*;

    logic row_ok, col_ok, keep;

    // hold off while the queue is full or the matrix store is being cleared
    assign s_tready = !status.q_full && !status.clearing;

    assign push_item.kind  = kind_t'(s_tuser);
    assign push_item.row   = s_tdata[4:0];
    assign push_item.col   = s_tdata[9:5];
    assign push_item.value = s_tdata[41:10];

    assign row_ok = (int'(s_tdata[4:0]) < MAX_SIZE);
    assign col_ok = (int'(s_tdata[9:5]) < MAX_SIZE);

    // classify the transfer
    always_comb
    begin
        if (s_tuser == KIND_LOAD_A)
            keep = row_ok && col_ok;
        else if (s_tuser == KIND_LOAD_B)
            keep = row_ok;
        else if (s_tuser == KIND_SOLVE)
            keep = 1'b1;
        else
            keep = 1'b0;
    end

    assign push = s_tvalid && s_tready && keep;

endmodule

// ===== sv/blu_div.sv =====
// Sequential rounding divider: Q32.32 accumulator by Q16.16 divisor, one quotient
// bit per cycle, result saturated to Q16.16. Depends on blu_pkg.
module blu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] acc,
    input  logic signed [31:0] dvs,
    output logic               done,
    output blu_pkg::q16_t      result
);
    import blu_pkg::*;

    logic        prep_reg, run_reg, fin_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [32:0] rem_reg;
    logic [31:0] dm_reg;
    logic        neg_reg;
    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_reg[31:0], num_reg[63]};
    assign take   = (rem_sh >= {1'b0, dm_reg});

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= 1'b0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            prep_reg <= start;
            fin_reg  <= run_reg && (cnt_reg == 6'd63);
            if (prep_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // operands: load magnitudes, add half divisor, then shift-subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= mag64(acc);
            dm_reg  <= dvs[31] ? (32'd0 - 32'(dvs)) : 32'(dvs);
            neg_reg <= acc[63] ^ dvs[31];
            rem_reg <= '0;
        end
        else if (prep_reg)
        begin
            num_reg <= num_reg + 64'(dm_reg >> 1);
        end
        else if (run_reg)
        begin
            rem_reg <= take ? (rem_sh - {1'b0, dm_reg}) : rem_sh;
            num_reg <= {num_reg[62:0], take};
        end
    end

    assign done   = fin_reg;
    assign result = pack_q(num_reg, neg_reg);

endmodule

// ===== sv/blu_back.sv =====
// Back end: executes loads and solves (banded Doolittle LU, forward and backward
// substitution) and drives the output register. Depends on blu_pkg, blu_ram, blu_div.
module blu_back #(
    parameter int MAX_SIZE = blu_pkg::MAX_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  blu_pkg::item_t                q_item,
    output logic                          q_pop,
    input  logic [5:0]                    size_in_use,
    input  logic [4:0]                    half_bandwidth,
    output logic                          clearing,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [blu_pkg::M_DATA_W-1:0]  m_tdata,  // index[4:0], solution[36:5], zero pad
    output logic [1:0]                    m_tuser,  // status
    output logic                          m_tlast
);
    import blu_pkg::*;

    localparam int NLIM   = (MAX_SIZE < RES_LIMIT) ? MAX_SIZE : RES_LIMIT;
    localparam int MDEPTH = MAX_SIZE * MAX_SIZE;
    localparam int MW     = $clog2(MDEPTH);
    localparam int IW     = $clog2(MAX_SIZE);

    function automatic logic [MW-1:0] maddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return MW'(MW'(r) * MW'(MAX_SIZE) + MW'(c));
    endfunction

    function automatic logic [CW-1:0] lo_bound(input logic [CW-1:0] x, input logic [4:0] h);
        return (x > CW'(h)) ? (x - CW'(h)) : '0;
    endfunction

    bk_state_t          state_reg, state_next;
    phase_t             phase_reg;
    logic [CW-1:0]      i_reg, j_reg, k_reg, n_reg;
    logic [4:0]         h_reg;
    logic signed [63:0] acc_reg, mul_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic signed [31:0] piv_reg, dvs_reg;
    logic               sat_reg;
    status_t            status_reg;
    logic [MW-1:0]      clr_reg;
    logic [MAX_SIZE-1:0] rvld_reg;
    logic               rv_reg;
    logic               ov_reg, olast_reg;
    logic [4:0]         oidx_reg;
    logic signed [31:0] osol_reg;
    status_t            ostat_reg;

    // memory ports
    logic          a_we, a_re, f_we, f1_re, f2_re, r_we, r_re, y_we, y_re, x_we, x_re;
    logic [MW-1:0] a_waddr, a_raddr, f_waddr, f1_raddr, f2_raddr;
    logic [31:0]   a_wdata, a_rdata, f1_rdata, f2_rdata, r_rdata, y_rdata, x_rdata;
    logic [IW-1:0] r_waddr, r_raddr, y_waddr, y_raddr, x_waddr, x_raddr;
    logic [31:0]   res_w;

    // control
    logic [CW-1:0] n_eff, kstart, kend, top;
    logic [CW:0]   tsum;
    logic          load_pop, solve_pop, wr_fire, go_out, zero_piv, out_load, div_start;
    q16_t          rnd_pk, div_res, res;
    logic          div_done;
    logic signed [31:0] op_b, init_v;
    acc_sat_t      sub_r;

    // effective order
    always_comb
    begin
        if (size_in_use == 6'd0)
            n_eff = CW'(1);
        else if (int'(size_in_use) > NLIM)
            n_eff = CW'(NLIM);
        else
            n_eff = CW'(size_in_use);
    end

    // band limits of the inner sum
    assign tsum = (CW+1)'(i_reg) + (CW+1)'(h_reg) + 1'b1;
    assign top  = (tsum < (CW+1)'(n_reg)) ? tsum[CW-1:0] : n_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_FU:
            begin
                kstart = lo_bound(j_reg, h_reg);
                kend   = i_reg;
            end
            PH_FL:
            begin
                kstart = lo_bound(i_reg, h_reg);
                kend   = j_reg;
            end
            PH_FWD:
            begin
                kstart = lo_bound(i_reg, h_reg);
                kend   = i_reg;
            end
            PH_BWD:
            begin
                kstart = i_reg + 1'b1;
                kend   = top;
            end
        endcase
    end

    // operand and initial-value selection
    always_comb
    begin
        unique case (phase_reg)
            PH_FU, PH_FL:
            begin
                op_b   = f2_rdata;
                init_v = a_rdata;
            end
            PH_FWD:
            begin
                op_b   = y_rdata;
                init_v = rv_reg ? r_rdata : 32'sd0;
            end
            PH_BWD:
            begin
                op_b   = x_rdata;
                init_v = y_rdata;
            end
        endcase
    end

    assign sub_r  = sat_sub(acc_reg, mul_reg);
    assign rnd_pk = pack_q((mag_reg + 64'd32768) >> 16, neg_reg);
    assign res    = (state_reg == ST_RND) ? rnd_pk : div_res;
    assign res_w  = res.val;

    assign load_pop  = (state_reg == ST_IDLE) && !q_empty && (q_item.kind != KIND_SOLVE);
    assign solve_pop = (state_reg == ST_IDLE) && !q_empty && (q_item.kind == KIND_SOLVE);
    assign wr_fire   = (state_reg == ST_RND) || ((state_reg == ST_DIVW) && div_done);
    assign zero_piv  = (phase_reg == PH_FU) && (i_reg == j_reg) && (res.val == 32'sd0);
    assign go_out    = zero_piv || ((phase_reg == PH_BWD) && (i_reg == '0));
    assign out_load  = (state_reg == ST_OUT_EMIT) && (!ov_reg || m_tready);
    assign div_start = (state_reg == ST_FIN) && (phase_reg == PH_FL || phase_reg == PH_BWD);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == MW'(MDEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:     if (solve_pop) state_next = ST_INIT;
            ST_INIT:     state_next = ST_INIT2;
            ST_INIT2:    state_next = ST_CHK;
            ST_CHK:      state_next = (k_reg < kend) ? ST_MUL : ST_FIN;
            ST_MUL:      state_next = ST_ACC;
            ST_ACC:      state_next = ST_CHK;
            ST_FIN:      state_next = div_start ? ST_DIVW : ST_RND;
            ST_RND:      state_next = go_out ? ST_OUT_RD : ST_INIT;
            ST_DIVW:     if (div_done) state_next = go_out ? ST_OUT_RD : ST_INIT;
            ST_OUT_RD:   state_next = ST_OUT_EMIT;
            ST_OUT_EMIT: if (out_load) state_next = (i_reg == n_reg - 1'b1) ? ST_IDLE : ST_OUT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory and queue controls
    always_comb
    begin
        q_pop    = load_pop || solve_pop;
        clearing = (state_reg == ST_CLEAR);

        a_we    = clearing || (load_pop && q_item.kind == KIND_LOAD_A);
        a_waddr = clearing ? clr_reg : maddr(CW'(q_item.row), CW'(q_item.col));
        a_wdata = clearing ? 32'd0 : q_item.value;
        a_re    = (state_reg == ST_INIT) && (phase_reg == PH_FU || phase_reg == PH_FL);
        a_raddr = maddr(i_reg, j_reg);

        r_we    = load_pop && (q_item.kind == KIND_LOAD_B);
        r_waddr = IW'(q_item.row);
        r_re    = (state_reg == ST_INIT) && (phase_reg == PH_FWD);
        r_raddr = i_reg[IW-1:0];

        f_we    = wr_fire && (phase_reg == PH_FU || phase_reg == PH_FL);
        f_waddr = maddr(i_reg, j_reg);
        f1_re   = (state_reg == ST_CHK) ||
                  ((state_reg == ST_INIT) && (phase_reg == PH_BWD));
        f1_raddr = (state_reg == ST_INIT) ? maddr(i_reg, i_reg) : maddr(i_reg, k_reg);
        f2_re   = (state_reg == ST_CHK) && (phase_reg == PH_FU || phase_reg == PH_FL);
        f2_raddr = maddr(k_reg, j_reg);

        y_we    = wr_fire && (phase_reg == PH_FWD);
        y_waddr = i_reg[IW-1:0];
        y_re    = ((state_reg == ST_CHK) && (phase_reg == PH_FWD)) ||
                  ((state_reg == ST_INIT) && (phase_reg == PH_BWD));
        y_raddr = (state_reg == ST_INIT) ? i_reg[IW-1:0] : k_reg[IW-1:0];

        x_we    = wr_fire && (phase_reg == PH_BWD);
        x_waddr = i_reg[IW-1:0];
        x_re    = ((state_reg == ST_CHK) && (phase_reg == PH_BWD)) || (state_reg == ST_OUT_RD);
        x_raddr = (state_reg == ST_OUT_RD) ? i_reg[IW-1:0] : k_reg[IW-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            phase_reg  <= PH_FU;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            n_reg      <= CW'(1);
            h_reg      <= '0;
            sat_reg    <= 1'b0;
            status_reg <= STAT_OK;
            clr_reg    <= '0;
            rvld_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (r_we)
            begin
                rvld_reg[r_waddr] <= 1'b1;
            end
            // start a solve
            if (solve_pop)
            begin
                phase_reg <= PH_FU;
                i_reg     <= '0;
                j_reg     <= '0;
                n_reg     <= n_eff;
                h_reg     <= half_bandwidth;
                sat_reg   <= 1'b0;
            end
            if (state_reg == ST_INIT2)
            begin
                k_reg <= kstart;
            end
            // accumulate one product
            if (state_reg == ST_ACC)
            begin
                k_reg   <= k_reg + 1'b1;
                sat_reg <= sat_reg | sub_r.sat;
            end
            // advance the element walk after each write-back
            if (wr_fire)
            begin
                sat_reg <= sat_reg | res.sat;
                unique case (phase_reg)
                    PH_FU:
                    begin
                        if (zero_piv)
                        begin
                            status_reg <= STAT_ZERO_PIVOT;
                            i_reg      <= '0;
                        end
                        else if (i_reg == j_reg)
                        begin
                            if (j_reg + 1'b1 < n_reg)
                            begin
                                phase_reg <= PH_FL;
                                i_reg     <= j_reg + 1'b1;
                            end
                            else
                            begin
                                phase_reg <= PH_FWD;
                                i_reg     <= '0;
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    PH_FL:
                    begin
                        if (i_reg + 1'b1 < n_reg)
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                        else
                        begin
                            phase_reg <= PH_FU;
                            j_reg     <= j_reg + 1'b1;
                            i_reg     <= '0;
                        end
                    end
                    PH_FWD:
                    begin
                        if (i_reg + 1'b1 < n_reg)
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                        else
                        begin
                            phase_reg <= PH_BWD;
                            i_reg     <= n_reg - 1'b1;
                        end
                    end
                    PH_BWD:
                    begin
                        if (i_reg == '0)
                        begin
                            status_reg <= (sat_reg | res.sat) ? STAT_SATURATED : STAT_OK;
                        end
                        else
                        begin
                            i_reg <= i_reg - 1'b1;
                        end
                    end
                endcase
            end
            // output register
            if (out_load)
            begin
                ov_reg <= 1'b1;
                i_reg  <= i_reg + 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INIT)
        begin
            rv_reg <= rvld_reg[i_reg[IW-1:0]];
        end
        if (state_reg == ST_INIT2)
        begin
            acc_reg <= wide_q(init_v);
            if (phase_reg == PH_BWD)
            begin
                dvs_reg <= f1_rdata;
            end
        end
        if (state_reg == ST_MUL)
        begin
            mul_reg <= $signed(f1_rdata) * op_b;
        end
        if (state_reg == ST_ACC)
        begin
            acc_reg <= sub_r.acc;
        end
        if (state_reg == ST_FIN)
        begin
            mag_reg <= mag64(acc_reg);
            neg_reg <= acc_reg[63];
        end
        if (wr_fire && phase_reg == PH_FU && i_reg == j_reg)
        begin
            piv_reg <= res.val;
        end
        if (out_load)
        begin
            oidx_reg  <= i_reg[4:0];
            osol_reg  <= (status_reg == STAT_ZERO_PIVOT) ? 32'sd0 : x_rdata;
            olast_reg <= (i_reg == n_reg - 1'b1);
            ostat_reg <= status_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, osol_reg, oidx_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    blu_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .acc    (acc_reg),
        .dvs    ((phase_reg == PH_FL) ? piv_reg : dvs_reg),
        .done   (div_done),
        .result (div_res)
    );

    blu_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_a_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
    );

    // two copies of the factor store give two read ports
    blu_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_f1_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(res_w),
        .re(f1_re), .raddr(f1_raddr), .rdata(f1_rdata)
    );

    blu_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_f2_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(res_w),
        .re(f2_re), .raddr(f2_raddr), .rdata(f2_rdata)
    );

    blu_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_r_ram (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(q_item.value),
        .re(r_re), .raddr(r_raddr), .rdata(r_rdata)
    );

    blu_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_y_ram (
        .clk(clk), .we(y_we), .waddr(y_waddr), .wdata(res_w),
        .re(y_re), .raddr(y_raddr), .rdata(y_rdata)
    );

    blu_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x_ram (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(res_w),
        .re(x_re), .raddr(x_raddr), .rdata(x_rdata)
    );

endmodule
